>>> rtl/tilt_compensated_compass_heading_assert.svh
// ----------------------------------------------------------------------------
// tilt compensated compass heading assertion macros
// shared concurrent assertion forms
// ----------------------------------------------------------------------------
`ifndef TILT_COMPENSATED_COMPASS_HEADING_ASSERT_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_ASSERT_SVH

// condition must never hold outside reset
`define TCCH_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TCCH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tcch_pkg.sv
// ----------------------------------------------------------------------------
// tcch_pkg
// constants, types and the arctangent table of the compass heading block
// ----------------------------------------------------------------------------
`default_nettype none
package tcch_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 16;

  localparam int MAG_W   = 16;
  localparam int ANG_W   = 26;
  localparam int HEAD_W  = 25;
  localparam int PH_W    = 32;
  localparam int MUL_W   = 38;
  localparam int MUL_LO  = 19;
  localparam int TRIG_W  = 33;
  localparam int HV_W    = 19;
  localparam int HPH_W   = 33;

  localparam logic [MUL_W-1:0] MUL_DEG = 38'd3054198966;
  localparam logic [MUL_W-1:0] MUL_RAD = 38'd174992710548;
  localparam logic [30:0]      PI_Q29  = 31'd1686629713;
  localparam logic [8:0]       DEG_360 = 9'd360;
  localparam int               INV_GAIN_Q30 = 652032874;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic signed [MAG_W-1:0] mx;
    logic signed [MAG_W-1:0] my;
    logic signed [MAG_W-1:0] mz;
    logic [PH_W-1:0]         ph_p;
    logic [PH_W-1:0]         ph_r;
  } item_t;

  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tcch_front.sv
// ----------------------------------------------------------------------------
// tcch_front
// takes input transactions and converts pitch and roll to turn phases
// ----------------------------------------------------------------------------
`default_nettype none
module tcch_front import tcch_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    deg,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [MAG_W-1:0] in_mag_x,
  input  wire logic signed [MAG_W-1:0] in_mag_y,
  input  wire logic signed [MAG_W-1:0] in_mag_z,
  input  wire logic signed [ANG_W-1:0] in_pitch_angle,
  input  wire logic signed [ANG_W-1:0] in_roll_angle,
  output logic                         push,
  output item_t                        push_item,
  input  wire logic                    full
);

  localparam int PW = ANG_W + MUL_W - MUL_LO;
  localparam logic [63:0] RND = 64'd1 << (7 + ANGLE_FRAC_BITS);

  logic adv;
  logic v1_r, v2_r;
  logic sp_r, sr_r;
  logic [PW-1:0] plo_r, phi_r, rlo_r, rhi_r;
  logic signed [MAG_W-1:0] mx_r, my_r, mz_r;
  item_t item_r;
  logic [MUL_W-1:0] mul;
  logic [ANG_W-1:0] mag_p, mag_r;
  logic [63:0] sum_p, sum_r;
  logic [PH_W-1:0] ph_p, ph_r;

  assign adv      = !v2_r || !full;
  assign in_ready = adv;
  assign push     = v2_r && !full;
  assign push_item = item_r;

  always_comb begin
    mul   = deg ? MUL_DEG : MUL_RAD;
    mag_p = in_pitch_angle[ANG_W-1] ? (~in_pitch_angle + 1'b1) : in_pitch_angle;
    mag_r = in_roll_angle[ANG_W-1] ? (~in_roll_angle + 1'b1) : in_roll_angle;
    sum_p = (64'(phi_r) << MUL_LO) + 64'(plo_r) + RND;
    sum_r = (64'(rhi_r) << MUL_LO) + 64'(rlo_r) + RND;
    ph_p  = sum_p[8+ANGLE_FRAC_BITS +: PH_W];
    ph_r  = sum_r[8+ANGLE_FRAC_BITS +: PH_W];
    if (sp_r) begin
      ph_p = -ph_p;
    end
    if (sr_r) begin
      ph_r = -ph_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_r  <= in_pitch_angle[ANG_W-1];
      sr_r  <= in_roll_angle[ANG_W-1];
      plo_r <= PW'(mag_p * mul[MUL_LO-1:0]);
      phi_r <= PW'(mag_p * mul[MUL_W-1:MUL_LO]);
      rlo_r <= PW'(mag_r * mul[MUL_LO-1:0]);
      rhi_r <= PW'(mag_r * mul[MUL_W-1:MUL_LO]);
      mx_r  <= in_mag_x;
      my_r  <= in_mag_y;
      mz_r  <= in_mag_z;
      item_r.mx   <= mx_r;
      item_r.my   <= my_r;
      item_r.mz   <= mz_r;
      item_r.ph_p <= ph_p;
      item_r.ph_r <= ph_r;
    end
  end

endmodule
`default_nettype wire

>>> rtl/tcch_fifo.sv
// ----------------------------------------------------------------------------
// tcch_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none
`include "tilt_compensated_compass_heading_assert.svh"
module tcch_fifo import tcch_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t wr_item,
  output logic       full,
  input  wire logic  pop,
  output logic       nempty,
  output item_t      rd_item
);

  item_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0] cnt_r;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign nempty  = (cnt_r != '0);
  assign rd_item = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  `TCCH_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full, "push while full")
  `TCCH_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && !nempty, "pop while empty")
  `TCCH_ASSERT_NEXT(a_cnt_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1,
                    "count did not grow")

endmodule
`default_nettype wire

>>> rtl/tcch_rot.sv
// ----------------------------------------------------------------------------
// tcch_rot
// pipelined rotation cordic giving cosine and sine in q30
// ----------------------------------------------------------------------------
`default_nettype none
module tcch_rot import tcch_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [PH_W-1:0]    ph,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  localparam int W = 34;

  logic signed [W-1:0] x_r [CORDIC_STAGES+1];
  logic signed [W-1:0] y_r [CORDIC_STAGES+1];
  logic signed [W-1:0] z_r [CORDIC_STAGES+1];
  logic [1:0]          q_r [CORDIC_STAGES+1];
  logic [PH_W-1:0]     p;

  assign p = ph + PH_W'(32'd536870912);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0] <= p[PH_W-1:PH_W-2];
      x_r[0] <= W'(INV_GAIN_Q30);
      y_r[0] <= '0;
      z_r[0] <= $signed({4'b0, p[29:0]}) - W'(32'sd536870912);
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
    localparam logic signed [W-1:0] AT = W'(atan_val(i));
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - AT;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + AT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[CORDIC_STAGES])
        2'd0: begin
          cos_o <= TRIG_W'(x_r[CORDIC_STAGES]);
          sin_o <= TRIG_W'(y_r[CORDIC_STAGES]);
        end
        2'd1: begin
          cos_o <= TRIG_W'(-y_r[CORDIC_STAGES]);
          sin_o <= TRIG_W'(x_r[CORDIC_STAGES]);
        end
        2'd2: begin
          cos_o <= TRIG_W'(-x_r[CORDIC_STAGES]);
          sin_o <= TRIG_W'(-y_r[CORDIC_STAGES]);
        end
        default: begin
          cos_o <= TRIG_W'(y_r[CORDIC_STAGES]);
          sin_o <= TRIG_W'(-x_r[CORDIC_STAGES]);
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/tcch_vec.sv
// ----------------------------------------------------------------------------
// tcch_vec
// pipelined vectoring cordic giving atan2 plus half a turn
// ----------------------------------------------------------------------------
`default_nettype none
module tcch_vec import tcch_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [HV_W-1:0] xh,
  input  wire logic signed [HV_W-1:0] yh,
  output logic [HPH_W-1:0]            h_o
);

  localparam int W  = 36;
  localparam int BW = 34;
  localparam logic signed [BW-1:0] HALF = BW'(64'sd2147483648);
  localparam logic signed [BW-1:0] QUAR = BW'(64'sd1073741824);

  logic signed [W-1:0]  x_r [CORDIC_STAGES+1];
  logic signed [W-1:0]  y_r [CORDIC_STAGES+1];
  logic signed [BW-1:0] z_r [CORDIC_STAGES+1];
  logic signed [BW-1:0] b_r [CORDIC_STAGES+1];
  logic                 s_r [CORDIC_STAGES+1];
  logic signed [BW-1:0] th;
  logic signed [W-1:0]  xs, ys;

  always_comb begin
    xs = W'(xh) <<< 14;
    ys = W'(yh) <<< 14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0] <= '0;
      if (yh == '0) begin
        s_r[0] <= 1'b1;
        b_r[0] <= (xh < 0) ? HALF : '0;
      end else if (xh == '0) begin
        s_r[0] <= 1'b1;
        b_r[0] <= (yh > 0) ? QUAR : -QUAR;
      end else begin
        s_r[0] <= 1'b0;
        b_r[0] <= (xh < 0) ? ((yh > 0) ? HALF : -HALF) : '0;
      end
      if (xh < 0) begin
        x_r[0] <= -xs;
        y_r[0] <= -ys;
      end else begin
        x_r[0] <= xs;
        y_r[0] <= ys;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
    localparam logic signed [BW-1:0] AT = BW'(atan_val(i));
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i+1] <= s_r[i];
        b_r[i+1] <= b_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + AT;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - AT;
        end
      end
    end
  end

  always_comb begin
    th = b_r[CORDIC_STAGES] + z_r[CORDIC_STAGES];
    if (s_r[CORDIC_STAGES]) begin
      th = b_r[CORDIC_STAGES];
    end else if (th > HALF) begin
      th = HALF;
    end else if (th < -HALF) begin
      th = -HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_o <= HPH_W'(th + HALF);
    end
  end

endmodule
`default_nettype wire

>>> rtl/tcch_back.sv
// ----------------------------------------------------------------------------
// tcch_back
// trig, tilt rotation, heading angle and output register
// ----------------------------------------------------------------------------
`default_nettype none
module tcch_back import tcch_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          deg,
  input  wire logic          nempty,
  input  wire item_t         rd_item,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [HEAD_W-1:0]  out_heading
);

  localparam int LAT_ROT = CORDIC_STAGES + 2;
  localparam int LAT_VEC = CORDIC_STAGES + 2;
  localparam int L       = LAT_ROT + 3 + LAT_VEC + 1;
  localparam int F       = ANGLE_FRAC_BITS;
  localparam logic [63:0] RND_DEG = 64'd1 << (31 - F);
  localparam logic [63:0] RND_RAD = 64'd1 << (59 - F);

  logic en;
  logic [L-1:0] v_r;
  logic signed [MAG_W-1:0] mx_d [LAT_ROT];
  logic signed [MAG_W-1:0] my_d [LAT_ROT];
  logic signed [MAG_W-1:0] mz_d [LAT_ROT];
  logic signed [TRIG_W-1:0] cp, sp, cr, sr;
  logic signed [65:0] srsp_f, srcp_f;
  logic signed [33:0] srsp_r, srcp_r;
  logic signed [49:0] mxcp_r, mzsp_r, mycr_r, mycr2_r, mxss_r, mzsc_r;
  logic signed [50:0] xq_r, yq;
  logic signed [MAG_W-1:0] mx2_r, mz2_r;
  logic signed [HV_W-1:0] xh_r, yh_r;
  logic [HPH_W-1:0] h;
  logic [63:0] prod_r, rsum;
  logic out_valid_r;
  logic [HEAD_W-1:0] out_heading_r;

  assign en          = !out_valid_r || out_ready;
  assign pop         = en && nempty;
  assign out_valid   = out_valid_r;
  assign out_heading = out_heading_r;

  tcch_rot u_rot_p (.clk(clk), .en(en), .ph(rd_item.ph_p), .cos_o(cp), .sin_o(sp));
  tcch_rot u_rot_r (.clk(clk), .en(en), .ph(rd_item.ph_r), .cos_o(cr), .sin_o(sr));

  always_ff @(posedge clk) begin
    if (en) begin
      mx_d[0] <= rd_item.mx;
      my_d[0] <= rd_item.my;
      mz_d[0] <= rd_item.mz;
      for (int k = 1; k < LAT_ROT; k++) begin
        mx_d[k] <= mx_d[k-1];
        my_d[k] <= my_d[k-1];
        mz_d[k] <= mz_d[k-1];
      end
    end
  end

  always_comb begin
    srsp_f = sr * sp;
    srcp_f = sr * cp;
    yq     = 51'(mxss_r) + 51'(mycr2_r) - 51'(mzsc_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srsp_r  <= 34'(srsp_f >>> 30);
      srcp_r  <= 34'(srcp_f >>> 30);
      mxcp_r  <= 50'(mx_d[LAT_ROT-1] * cp);
      mzsp_r  <= 50'(mz_d[LAT_ROT-1] * sp);
      mycr_r  <= 50'(my_d[LAT_ROT-1] * cr);
      mx2_r   <= mx_d[LAT_ROT-1];
      mz2_r   <= mz_d[LAT_ROT-1];
      xq_r    <= 51'(mxcp_r) + 51'(mzsp_r);
      mxss_r  <= 50'(mx2_r * srsp_r);
      mzsc_r  <= 50'(mz2_r * srcp_r);
      mycr2_r <= mycr_r;
      xh_r    <= HV_W'((xq_r + (xq_r[50] ? 51'sd1073741823 : 51'sd0)) >>> 30);
      yh_r    <= HV_W'((yq + (yq[50] ? 51'sd1073741823 : 51'sd0)) >>> 30);
    end
  end

  tcch_vec u_vec (.clk(clk), .en(en), .xh(xh_r), .yh(yh_r), .h_o(h));

  always_comb begin
    if (deg) begin
      rsum = (prod_r + RND_DEG) >> (32 - F);
    end else begin
      rsum = (prod_r + RND_RAD) >> (60 - F);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= deg ? 64'(h * DEG_360) : 64'(h * PI_Q29);
      out_heading_r <= rsum[HEAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[L-2:0], nempty};
      out_valid_r <= v_r[L-1];
    end
  end

endmodule
`default_nettype wire

>>> rtl/tilt_compensated_compass_heading.sv
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading
// tilt compensated magnetometer heading, unless stalled one transaction per cycle
// ----------------------------------------------------------------------------
// Takes one transaction per clock while in_ready is high and gives one
// heading per transaction, in order. Most of the delay lies in the CORDIC
// pipelines of the back end; the front converts the angles to turn phases in
// two stages and a four-entry queue decouples it from the back end. cfg_wdata
// selects degrees (1, reset) or radians (0) for angles and heading; the user
// must ensure it is written only while the block is idle (not enforced).
`default_nettype none
module tilt_compensated_compass_heading import tcch_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [MAG_W-1:0] in_mag_x,
  input  wire logic signed [MAG_W-1:0] in_mag_y,
  input  wire logic signed [MAG_W-1:0] in_mag_z,
  input  wire logic signed [ANG_W-1:0] in_pitch_angle,
  input  wire logic signed [ANG_W-1:0] in_roll_angle,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [HEAD_W-1:0]            out_heading
);

  logic deg_r;
  logic push, full, pop, nempty;
  item_t wr_item, rd_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= 1'b1;
    end else if (cfg_we) begin
      deg_r <= cfg_wdata;
    end
  end

  tcch_front u_front (
    .clk(clk), .rst_n(rst_n), .deg(deg_r),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mag_x(in_mag_x), .in_mag_y(in_mag_y), .in_mag_z(in_mag_z),
    .in_pitch_angle(in_pitch_angle), .in_roll_angle(in_roll_angle),
    .push(push), .push_item(wr_item), .full(full)
  );

  tcch_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_item(wr_item), .full(full),
    .pop(pop), .nempty(nempty), .rd_item(rd_item)
  );

  tcch_back u_back (
    .clk(clk), .rst_n(rst_n), .deg(deg_r), .nempty(nempty), .rd_item(rd_item),
    .pop(pop), .out_valid(out_valid), .out_ready(out_ready),
    .out_heading(out_heading)
  );

endmodule
`default_nettype wire
